// ===== rtl/aff2i_pkg.sv =====
// Shared types and constants for the 2D affine matrix inverse pipeline.
// No dependencies; every other file in rtl/ imports this package.
package aff2i_pkg;

   localparam int DATA_W    = 32;
   localparam int DET_W     = 64;
   localparam int QUO_W     = 33;
   localparam int DIV_STEPS = 32;
   localparam int LANES     = 4;

   // Front end stages, one register per divider step, back end stages.
   localparam int FRONT_STAGES = 4;
   localparam int BACK_STAGES  = 3;
   localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

   localparam logic [DATA_W-1:0] DET_THRESHOLD_RESET = 32'd43;

   // Lane numbers: which numerator each divider lane works on.
   localparam int LANE_A = 0;   // d / det
   localparam int LANE_B = 1;   // -b / det
   localparam int LANE_C = 2;   // -c / det
   localparam int LANE_D = 3;   // a / det

   // One divider lane: partial remainder, quotient bits so far, sign, overflow.
   typedef struct packed {
      logic [DET_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } div_lane_type;

   // One word travelling through the divider stages.
   typedef struct packed {
      logic                     valid;
      logic                     invertible;
      logic [DET_W-1:0]         dmag;
      logic signed [DATA_W-1:0] tx;
      logic signed [DATA_W-1:0] ty;
      div_lane_type [LANES-1:0] lane;
   } div_word_type;

endpackage

// ===== rtl/aff2i_front.sv =====
// Front end: determinant products, determinant, magnitude and singular test,
// and the first quotient bit. Depends on aff2i_pkg.
module aff2i_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic signed [31:0]                m_a,
   input  logic signed [31:0]                m_b,
   input  logic signed [31:0]                m_c,
   input  logic signed [31:0]                m_d,
   input  logic signed [31:0]                m_tx,
   input  logic signed [31:0]                m_ty,
   input  logic [31:0]                       det_threshold,
   output aff2i_pkg::div_word_type           word_out
);
   import aff2i_pkg::*;

   // Stage 1 registers.
   logic                     s1_valid_ff;
   logic signed [DET_W-1:0]  p_ad_ff, p_bc_ff;
   logic signed [DATA_W-1:0] s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff, s1_tx_ff, s1_ty_ff;
   // Stage 2 registers.
   logic                     s2_valid_ff;
   logic signed [DET_W-1:0]  det_ff;
   logic signed [DATA_W-1:0] s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff, s2_tx_ff, s2_ty_ff;
   // Stage 3 registers.
   logic                     s3_valid_ff;
   logic                     s3_inv_ff;
   logic [DET_W-1:0]         s3_dmag_ff;
   logic [DATA_W-1:0]        s3_nmag_ff [LANES];
   logic                     s3_neg_ff  [LANES];
   logic signed [DATA_W-1:0] s3_tx_ff, s3_ty_ff;
   // Stage 3 next values.
   logic                     det_neg;
   logic [DET_W-1:0]         dmag_in;
   logic [DATA_W-1:0]        nmag_in [LANES];
   logic                     neg_in  [LANES];
   logic signed [DATA_W-1:0] num     [LANES];
   logic                     negate  [LANES];
   // Stage 4.
   div_word_type             word_in, word_ff;

   // Stage 1: the two exact products of the determinant.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      p_ad_ff  <= DET_W'(m_a) * DET_W'(m_d);
      p_bc_ff  <= DET_W'(m_b) * DET_W'(m_c);
      s1_a_ff  <= m_a;
      s1_b_ff  <= m_b;
      s1_c_ff  <= m_c;
      s1_d_ff  <= m_d;
      s1_tx_ff <= m_tx;
      s1_ty_ff <= m_ty;
   end

   // Stage 2: the determinant in Q32.32; it always fits in 64 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      det_ff   <= p_ad_ff - p_bc_ff;
      s2_a_ff  <= s1_a_ff;
      s2_b_ff  <= s1_b_ff;
      s2_c_ff  <= s1_c_ff;
      s2_d_ff  <= s1_d_ff;
      s2_tx_ff <= s1_tx_ff;
      s2_ty_ff <= s1_ty_ff;
   end

   // Stage 3: magnitudes and signs of the determinant and the four numerators.
   always_comb begin
      det_neg = det_ff[DET_W-1];
      dmag_in = det_neg ? DET_W'(-det_ff) : DET_W'(det_ff);
      num[LANE_A]    = s2_d_ff;
      num[LANE_B]    = s2_b_ff;
      num[LANE_C]    = s2_c_ff;
      num[LANE_D]    = s2_a_ff;
      negate[LANE_A] = 1'b0;
      negate[LANE_B] = 1'b1;
      negate[LANE_C] = 1'b1;
      negate[LANE_D] = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         nmag_in[i] = num[i][DATA_W-1] ? DATA_W'(-num[i]) : DATA_W'(num[i]);
         neg_in[i]  = num[i][DATA_W-1] ^ det_neg ^ negate[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_inv_ff  <= dmag_in > {{(DET_W-DATA_W){1'b0}}, det_threshold};
      s3_dmag_ff <= dmag_in;
      for (int i = 0; i < LANES; i++) begin
         s3_nmag_ff[i] <= nmag_in[i];
         s3_neg_ff[i]  <= neg_in[i];
      end
      s3_tx_ff <= s2_tx_ff;
      s3_ty_ff <= s2_ty_ff;
   end

   // Stage 4: overflow test (quotient of 2^33 or more) and the top quotient bit.
   always_comb begin
      word_in.valid      = s3_valid_ff;
      word_in.invertible = s3_inv_ff;
      word_in.dmag       = s3_dmag_ff;
      word_in.tx         = s3_tx_ff;
      word_in.ty         = s3_ty_ff;
      for (int i = 0; i < LANES; i++) begin
         word_in.lane[i].neg = s3_neg_ff[i];
         word_in.lane[i].ovf = {{(DET_W-DATA_W+1){1'b0}}, s3_nmag_ff[i]}
                               >= {s3_dmag_ff, 1'b0};
         if ({{(DET_W-DATA_W){1'b0}}, s3_nmag_ff[i]} >= s3_dmag_ff) begin
            word_in.lane[i].quo = QUO_W'(1);
            word_in.lane[i].rem = {{(DET_W-DATA_W){1'b0}}, s3_nmag_ff[i]} - s3_dmag_ff;
         end else begin
            word_in.lane[i].quo = '0;
            word_in.lane[i].rem = {{(DET_W-DATA_W){1'b0}}, s3_nmag_ff[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== rtl/aff2i_div_step.sv =====
// One restoring division step for all four lanes, one quotient bit each.
// Depends on aff2i_pkg.
module aff2i_div_step (
   input  logic                    clock,
   input  logic                    reset,
   input  aff2i_pkg::div_word_type word_in_d,
   output aff2i_pkg::div_word_type word_out
);
   import aff2i_pkg::*;

   div_word_type   word_in, word_ff;
   logic [DET_W:0] rem2 [LANES];
   logic           ge   [LANES];

   // Double the remainder, subtract the divisor where it fits.
   always_comb begin
      word_in = word_in_d;
      for (int i = 0; i < LANES; i++) begin
         rem2[i] = {word_in_d.lane[i].rem, 1'b0};
         ge[i]   = rem2[i] >= {1'b0, word_in_d.dmag};
         word_in.lane[i].rem = ge[i] ? DET_W'(rem2[i] - {1'b0, word_in_d.dmag})
                                     : rem2[i][DET_W-1:0];
         word_in.lane[i].quo = {word_in_d.lane[i].quo[QUO_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== rtl/aff2i_back.sv =====
// Back end: quotient saturation, translation products and final result word.
// Depends on aff2i_pkg.
module aff2i_back (
   input  logic                    clock,
   input  logic                    reset,
   input  aff2i_pkg::div_word_type word_in_d,
   output logic                    rsp_valid,
   output logic                    rsp_invertible,
   output logic                    rsp_saturated,
   output logic signed [31:0]      rsp_inv_a,
   output logic signed [31:0]      rsp_inv_b,
   output logic signed [31:0]      rsp_inv_c,
   output logic signed [31:0]      rsp_inv_d,
   output logic signed [31:0]      rsp_inv_tx,
   output logic signed [31:0]      rsp_inv_ty
);
   import aff2i_pkg::*;

   localparam logic signed [49:0] MAX50 = 50'sh7FFFFFFF;
   localparam logic signed [49:0] MIN50 = -50'sh80000000;

   // Stage B1 registers.
   logic                     b1_valid_ff, b1_inv_ff, b1_sat_ff;
   logic signed [DATA_W-1:0] b1_r_ff [LANES];
   logic signed [DATA_W-1:0] b1_tx_ff, b1_ty_ff;
   logic signed [DATA_W-1:0] r_in [LANES];
   logic                     sat_in;
   logic [QUO_W-1:0]         q;
   logic                     neg_eff;
   // Stage B2 registers.
   logic                     b2_valid_ff, b2_inv_ff, b2_sat_ff;
   logic signed [DATA_W-1:0] b2_r_ff [LANES];
   logic signed [DET_W-1:0]  b2_p_ff [LANES];
   // Stage B3.
   logic signed [48:0]       sum_x, sum_y;
   logic signed [49:0]       neg_x, neg_y;
   logic signed [DATA_W-1:0] tx_in, ty_in;
   logic                     sat_t;
   logic                     valid_ff, inv_ff, sat_ff;
   logic signed [DATA_W-1:0] a_ff, b_ff, c_ff, d_ff, tx_ff, ty_ff;

   // Stage B1: signed quotient clipped to Q16.16; a zero quotient is positive.
   always_comb begin
      sat_in  = 1'b0;
      q       = '0;
      neg_eff = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         q       = word_in_d.lane[i].quo;
         neg_eff = word_in_d.lane[i].neg && (word_in_d.lane[i].ovf || q != '0);
         if (neg_eff) begin
            if (word_in_d.lane[i].ovf || q > 33'h080000000) begin
               r_in[i] = 32'sh80000000;
               sat_in  = 1'b1;
            end else begin
               r_in[i] = DATA_W'(-q);
            end
         end else begin
            if (word_in_d.lane[i].ovf || q > 33'h07FFFFFFF) begin
               r_in[i] = 32'sh7FFFFFFF;
               sat_in  = 1'b1;
            end else begin
               r_in[i] = q[DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= word_in_d.valid;
      end
      b1_inv_ff <= word_in_d.invertible;
      b1_sat_ff <= sat_in;
      for (int i = 0; i < LANES; i++) begin
         b1_r_ff[i] <= r_in[i];
      end
      b1_tx_ff <= word_in_d.tx;
      b1_ty_ff <= word_in_d.ty;
   end

   // Stage B2: the four translation products, each exact.
   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
      b2_inv_ff  <= b1_inv_ff;
      b2_sat_ff  <= b1_sat_ff;
      b2_r_ff    <= b1_r_ff;
      b2_p_ff[0] <= DET_W'(b1_r_ff[LANE_A]) * DET_W'(b1_tx_ff);
      b2_p_ff[1] <= DET_W'(b1_r_ff[LANE_B]) * DET_W'(b1_ty_ff);
      b2_p_ff[2] <= DET_W'(b1_r_ff[LANE_C]) * DET_W'(b1_tx_ff);
      b2_p_ff[3] <= DET_W'(b1_r_ff[LANE_D]) * DET_W'(b1_ty_ff);
   end

   // Stage B3: floor shift, sum, negate and clip the translation.
   always_comb begin
      sum_x = 49'(b2_p_ff[0] >>> 16) + 49'(b2_p_ff[1] >>> 16);
      sum_y = 49'(b2_p_ff[2] >>> 16) + 49'(b2_p_ff[3] >>> 16);
      neg_x = -50'(sum_x);
      neg_y = -50'(sum_y);
      sat_t = 1'b0;
      if (neg_x > MAX50) begin
         tx_in = 32'sh7FFFFFFF;
         sat_t = 1'b1;
      end else if (neg_x < MIN50) begin
         tx_in = 32'sh80000000;
         sat_t = 1'b1;
      end else begin
         tx_in = neg_x[DATA_W-1:0];
      end
      if (neg_y > MAX50) begin
         ty_in = 32'sh7FFFFFFF;
         sat_t = 1'b1;
      end else if (neg_y < MIN50) begin
         ty_in = 32'sh80000000;
         sat_t = 1'b1;
      end else begin
         ty_in = neg_y[DATA_W-1:0];
      end
   end

   // Output word; a singular matrix gives all zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= b2_valid_ff;
      end
      inv_ff <= b2_inv_ff;
      if (b2_inv_ff) begin
         sat_ff <= b2_sat_ff | sat_t;
         a_ff   <= b2_r_ff[LANE_A];
         b_ff   <= b2_r_ff[LANE_B];
         c_ff   <= b2_r_ff[LANE_C];
         d_ff   <= b2_r_ff[LANE_D];
         tx_ff  <= tx_in;
         ty_ff  <= ty_in;
      end else begin
         sat_ff <= 1'b0;
         a_ff   <= '0;
         b_ff   <= '0;
         c_ff   <= '0;
         d_ff   <= '0;
         tx_ff  <= '0;
         ty_ff  <= '0;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_invertible = inv_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_inv_a      = a_ff;
   assign rsp_inv_b      = b_ff;
   assign rsp_inv_c      = c_ff;
   assign rsp_inv_d      = d_ff;
   assign rsp_inv_tx     = tx_ff;
   assign rsp_inv_ty     = ty_ff;

endmodule

// ===== rtl/affine_2d_inverse_core.sv =====
// From start to the rsp_valid strobe a matrix passes 4 front end stages,
// 32 divider stages of one quotient bit each and 3 back end stages.
// Throughput: one matrix per cycle; busy is high only during reset.
// Reset is synchronous and active high; it empties the pipeline and loads
// det_threshold with 43. Results cannot be stalled by the receiver.
module affine_2d_inverse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_m_a,
   input  logic signed [31:0] req_m_b,
   input  logic signed [31:0] req_m_c,
   input  logic signed [31:0] req_m_d,
   input  logic signed [31:0] req_m_tx,
   input  logic signed [31:0] req_m_ty,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_wdata,
   output logic               rsp_valid,
   output logic               rsp_invertible,
   output logic               rsp_saturated,
   output logic signed [31:0] rsp_inv_a,
   output logic signed [31:0] rsp_inv_b,
   output logic signed [31:0] rsp_inv_c,
   output logic signed [31:0] rsp_inv_d,
   output logic signed [31:0] rsp_inv_tx,
   output logic signed [31:0] rsp_inv_ty
);
   import aff2i_pkg::*;

   logic [DATA_W-1:0] thr_ff;
   logic              accept;
   div_word_type      div_word [DIV_STEPS+1];

   // Handshake: every word is taken except during reset.
   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // Singular threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= DET_THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_wdata;
      end
   end

   aff2i_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .m_a           (req_m_a),
      .m_b           (req_m_b),
      .m_c           (req_m_c),
      .m_d           (req_m_d),
      .m_tx          (req_m_tx),
      .m_ty          (req_m_ty),
      .det_threshold (thr_ff),
      .word_out      (div_word[0])
   );

   // Divider chain, one quotient bit per stage.
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      aff2i_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .word_in_d (div_word[s]),
         .word_out  (div_word[s+1])
      );
   end

   aff2i_back u_back (
      .clock          (clock),
      .reset          (reset),
      .word_in_d      (div_word[DIV_STEPS]),
      .rsp_valid      (rsp_valid),
      .rsp_invertible (rsp_invertible),
      .rsp_saturated  (rsp_saturated),
      .rsp_inv_a      (rsp_inv_a),
      .rsp_inv_b      (rsp_inv_b),
      .rsp_inv_c      (rsp_inv_c),
      .rsp_inv_d      (rsp_inv_d),
      .rsp_inv_tx     (rsp_inv_tx),
      .rsp_inv_ty     (rsp_inv_ty)
   );

endmodule

// ===== rtl/aff2i_checker.sv =====
// Port-level checks for the affine inverse core, bound to its top level.
// Depends on aff2i_pkg and affine_2d_inverse_core.
module aff2i_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_m_a,
   input logic signed [31:0] req_m_b,
   input logic signed [31:0] req_m_c,
   input logic signed [31:0] req_m_d,
   input logic               rsp_valid,
   input logic               rsp_invertible,
   input logic               rsp_saturated,
   input logic signed [31:0] rsp_inv_a,
   input logic signed [31:0] rsp_inv_b,
   input logic signed [31:0] rsp_inv_c,
   input logic signed [31:0] rsp_inv_d,
   input logic signed [31:0] rsp_inv_tx,
   input logic signed [31:0] rsp_inv_ty
);
   import aff2i_pkg::*;

   logic acc;
   logic zero_det;

   assign acc      = start && !busy;
   assign zero_det = (req_m_b == 32'sd0 || req_m_c == 32'sd0)
                     && (req_m_a == 32'sd0 || req_m_d == 32'sd0);

   // Every result word matches a word taken a fixed latency earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(acc, PIPE_LATENCY))
      else $error("result strobe does not match accepted word");

   // A singular result carries all zero values.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invertible |-> !rsp_saturated && rsp_inv_a == 0
      && rsp_inv_b == 0 && rsp_inv_c == 0 && rsp_inv_d == 0
      && rsp_inv_tx == 0 && rsp_inv_ty == 0)
      else $error("singular result with nonzero values");

   // A matrix whose two determinant products are both zero is never reported invertible.
   a_zero_det: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(acc && zero_det, PIPE_LATENCY) |-> !rsp_invertible)
      else $error("zero determinant reported invertible");

endmodule

bind affine_2d_inverse_core aff2i_checker u_aff2i_checker (.*);
